FILE: hdl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies.
package qrs_pkg;

	// width of the fixed-point result words
	localparam int unsigned OUT_W = 40;

	typedef enum logic [1:0] {
		KIND_TWO_REAL = 2'd0,
		KIND_REPEATED = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_REJECTED = 2'd3
	} kind_t;

endpackage

FILE: hdl/qrs_sqrt_cell.sv
// One cell of the digit-by-digit square root chain: one root bit per cell.
// Standalone; no package needed.
module qrs_sqrt_cell #(
	parameter int unsigned PAIRS = 33,
	parameter int unsigned SW    = 41
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  logic [2*PAIRS-1:0]   rad_in,
	input  logic [PAIRS+1:0]     rem_in,
	input  logic [PAIRS-1:0]     root_in,
	input  logic [SW-1:0]        side_in,
	output logic                 v_s1,
	output logic [2*PAIRS-1:0]   rad_s1,
	output logic [PAIRS+1:0]     rem_s1,
	output logic [PAIRS-1:0]     root_s1,
	output logic [SW-1:0]        side_s1
);
	localparam int unsigned RW = 2 * PAIRS;
	localparam int unsigned TW = PAIRS + 4;

	logic [TW-1:0] rem_sh;
	logic [TW-1:0] trial;
	logic [TW-1:0] diff;
	logic          ge;

	// bring down the next radicand pair, try 4*root+1
	assign rem_sh = {rem_in, rad_in[RW-1 -: 2]};
	assign trial  = TW'({root_in, 2'b01});
	assign ge     = (rem_sh >= trial);
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= {rad_in[RW-3:0], 2'b00};
			rem_s1  <= ge ? diff[PAIRS+1:0] : rem_sh[PAIRS+1:0];
			root_s1 <= {root_in[PAIRS-2:0], ge};
			side_s1 <= side_in;
		end
	end

endmodule

FILE: hdl/qrs_div_cell.sv
// One cell of the restoring divider chain: one quotient bit per cell.
// Standalone; no package needed.
module qrs_div_cell #(
	parameter int unsigned NW  = 34,
	parameter int unsigned DVW = 17,
	parameter int unsigned SW  = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  logic [NW-1:0]    num_in,
	input  logic [NW-1:0]    quo_in,
	input  logic [DVW-1:0]   rem_in,
	input  logic [DVW-1:0]   dv_in,
	input  logic [SW-1:0]    side_in,
	output logic             v_s1,
	output logic [NW-1:0]    num_s1,
	output logic [NW-1:0]    quo_s1,
	output logic [DVW-1:0]   rem_s1,
	output logic [DVW-1:0]   dv_s1,
	output logic [SW-1:0]    side_s1
);
	logic [DVW:0] rs;
	logic [DVW:0] diff;
	logic         ge;

	assign rs   = {rem_in, num_in[NW-1]};
	assign ge   = (rs >= {1'b0, dv_in});
	assign diff = rs - {1'b0, dv_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= {num_in[NW-2:0], 1'b0};
			quo_s1  <= {quo_in[NW-2:0], ge};
			rem_s1  <= ge ? diff[DVW-1:0] : rs[DVW-1:0];
			dv_s1   <= dv_in;
			side_s1 <= side_in;
		end
	end

endmodule

FILE: hdl/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: front end, square root chain,
// two divider chains, saturation and output skid. Uses qrs_pkg and the cells.
//
// Roots of a*x^2 + b*x + c for signed coefficients. One request is accepted
// per clock and one result comes back per request, in order. A set with any
// zero coefficient returns kind 3 with both values zero. Otherwise the
// discriminant D = b*b - 4ac is formed exactly; D > 0 gives two real roots
// (B+S)/2a and (B-S)/2a, D == 0 a repeated root B/2a twice, D < 0 the real
// part B/2a and the imaginary magnitude S/|2a|, where B = -b*2^FRAC_BITS and
// S = floor(sqrt(|D|)*2^FRAC_BITS). Quotients truncate toward zero and
// saturate to 40 bits. The square root chain has COEF_WIDTH+1+FRAC_BITS
// cells, each divider chain COEF_WIDTH+2+FRAC_BITS. Every cell retires one
// bit per clock for a different request, so throughput is one request per
// cycle while the pipeline is not halted. The whole pipeline halts only
// while the output skid register is occupied; in_stall is a register.
module quadratic_root_solver_unit #(
	parameter int unsigned COEF_WIDTH = 16,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COEF_WIDTH-1:0]      coef_quad,
	input  logic signed [COEF_WIDTH-1:0]      coef_lin,
	input  logic signed [COEF_WIDTH-1:0]      coef_const,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        kind,
	output logic signed [qrs_pkg::OUT_W-1:0]  first_value,
	output logic signed [qrs_pkg::OUT_W-1:0]  second_value
);
	import qrs_pkg::*;

	localparam int unsigned W     = COEF_WIDTH;
	localparam int unsigned F     = FRAC_BITS;
	localparam int unsigned DW    = 2 * W + 2;      // discriminant, signed
	localparam int unsigned PAIRS = W + 1 + F;      // root bits
	localparam int unsigned RW    = 2 * PAIRS;      // radicand bits
	localparam int unsigned BW    = W + 1 + F;      // -b scaled, signed
	localparam int unsigned DVW   = W + 1;          // |2a|
	localparam int unsigned NW    = W + 2 + F;      // numerator magnitude
	localparam int unsigned SNW   = NW + 1;         // numerator, signed
	localparam int unsigned SQSW  = 2 + BW + 1 + DVW;
	localparam int unsigned EW    = (NW + 1 > OUT_W) ? NW + 1 : OUT_W + 1;

	localparam logic signed [EW-1:0] OMAX = EW'({(OUT_W - 1){1'b1}});
	localparam logic signed [EW-1:0] OMIN = ~OMAX;

	logic en;

	// ---------------- stage 1: products ----------------
	logic                      v_s1;
	logic signed [W-1:0]       a_s1, b_s1;
	logic signed [2*W-1:0]     bb_s1, ac_s1;
	logic                      zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= coef_quad;
			b_s1    <= coef_lin;
			bb_s1   <= coef_lin * coef_lin;
			ac_s1   <= coef_quad * coef_const;
			zero_s1 <= (coef_quad == '0) || (coef_lin == '0) || (coef_const == '0);
		end
	end

	// ---------------- stage 2: discriminant, classify ----------------
	logic signed [DW-1:0]  d_w;
	logic [DW-2:0]         dmag_w;
	logic signed [BW-1:0]  bneg_w;
	logic [W-1:0]          amag_w;
	kind_t                 kind_w;

	assign d_w    = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
	assign dmag_w = d_w[DW-1] ? (DW-1)'(-d_w) : d_w[DW-2:0];
	assign bneg_w = -(BW'(b_s1));
	assign amag_w = a_s1[W-1] ? W'(-a_s1) : W'(a_s1);

	always_comb begin
		if (zero_s1) begin
			kind_w = KIND_REJECTED;
		end else if (d_w[DW-1]) begin
			kind_w = KIND_COMPLEX;
		end else if (d_w == '0) begin
			kind_w = KIND_REPEATED;
		end else begin
			kind_w = KIND_TWO_REAL;
		end
	end

	logic                  v_s2;
	logic [RW-1:0]         rad_s2;
	logic [SQSW-1:0]       side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// side word: kind, -b scaled, sign of 2a, |2a|
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2  <= RW'(dmag_w) << (2 * F);
			side_s2 <= {kind_w, bneg_w <<< F, a_s1[W-1], amag_w, 1'b0};
		end
	end

	// ---------------- square root chain ----------------
	logic                sq_v    [PAIRS+1];
	logic [RW-1:0]       sq_rad  [PAIRS+1];
	logic [PAIRS+1:0]    sq_rem  [PAIRS+1];
	logic [PAIRS-1:0]    sq_root [PAIRS+1];
	logic [SQSW-1:0]     sq_side [PAIRS+1];

	assign sq_v[0]    = v_s2;
	assign sq_rad[0]  = rad_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s2;

	for (genvar i = 0; i < PAIRS; i++) begin : g_sqrt
		qrs_sqrt_cell #(.PAIRS(PAIRS), .SW(SQSW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (sq_v[i]),
			.rad_in  (sq_rad[i]),
			.rem_in  (sq_rem[i]),
			.root_in (sq_root[i]),
			.side_in (sq_side[i]),
			.v_s1    (sq_v[i+1]),
			.rad_s1  (sq_rad[i+1]),
			.rem_s1  (sq_rem[i+1]),
			.root_s1 (sq_root[i+1]),
			.side_s1 (sq_side[i+1])
		);
	end

	// ---------------- stage 3: numerators ----------------
	kind_t                 sq_kind;
	logic signed [BW-1:0]  sq_bneg;
	logic                  sq_dneg;
	logic [DVW-1:0]        sq_dmag;
	logic signed [SNW-1:0] bx, sx, n1_w, n2_w;
	logic                  neg1_w, neg2_w;

	assign sq_kind = kind_t'(sq_side[PAIRS][SQSW-1 -: 2]);
	assign sq_bneg = sq_side[PAIRS][SQSW-3 -: BW];
	assign sq_dneg = sq_side[PAIRS][DVW];
	assign sq_dmag = sq_side[PAIRS][DVW-1:0];
	assign bx      = SNW'(sq_bneg);
	assign sx      = $signed({2'b00, sq_root[PAIRS]});

	always_comb begin
		n1_w = bx;
		n2_w = bx;
		unique case (sq_kind)
			KIND_TWO_REAL: begin
				n1_w = bx + sx;
				n2_w = bx - sx;
			end
			KIND_COMPLEX: begin
				n2_w = sx;
			end
			default: begin
			end
		endcase
	end

	assign neg1_w = n1_w[SNW-1] ^ sq_dneg;
	// imaginary magnitude divides by |2a|
	assign neg2_w = (sq_kind == KIND_COMPLEX) ? 1'b0 : (n2_w[SNW-1] ^ sq_dneg);

	logic              v_s3;
	logic [NW-1:0]     n1_s3, n2_s3;
	logic [DVW-1:0]    dv_s3;
	logic [2:0]        side1_s3;
	logic              side2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v[PAIRS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s3    <= n1_w[SNW-1] ? NW'(-n1_w) : n1_w[NW-1:0];
			n2_s3    <= n2_w[SNW-1] ? NW'(-n2_w) : n2_w[NW-1:0];
			dv_s3    <= sq_dmag;
			side1_s3 <= {sq_kind, neg1_w};
			side2_s3 <= neg2_w;
		end
	end

	// ---------------- divider chains ----------------
	logic              d1_v   [NW+1];
	logic [NW-1:0]     d1_num [NW+1];
	logic [NW-1:0]     d1_quo [NW+1];
	logic [DVW-1:0]    d1_rem [NW+1];
	logic [DVW-1:0]    d1_dv  [NW+1];
	logic [2:0]        d1_side[NW+1];
	logic              d2_v   [NW+1];
	logic [NW-1:0]     d2_num [NW+1];
	logic [NW-1:0]     d2_quo [NW+1];
	logic [DVW-1:0]    d2_rem [NW+1];
	logic [DVW-1:0]    d2_dv  [NW+1];
	logic [0:0]        d2_side[NW+1];

	assign d1_v[0]    = v_s3;
	assign d1_num[0]  = n1_s3;
	assign d1_quo[0]  = '0;
	assign d1_rem[0]  = '0;
	assign d1_dv[0]   = dv_s3;
	assign d1_side[0] = side1_s3;
	assign d2_v[0]    = v_s3;
	assign d2_num[0]  = n2_s3;
	assign d2_quo[0]  = '0;
	assign d2_rem[0]  = '0;
	assign d2_dv[0]   = dv_s3;
	assign d2_side[0] = side2_s3;

	for (genvar i = 0; i < NW; i++) begin : g_div
		qrs_div_cell #(.NW(NW), .DVW(DVW), .SW(3)) u_first (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (d1_v[i]),
			.num_in  (d1_num[i]),
			.quo_in  (d1_quo[i]),
			.rem_in  (d1_rem[i]),
			.dv_in   (d1_dv[i]),
			.side_in (d1_side[i]),
			.v_s1    (d1_v[i+1]),
			.num_s1  (d1_num[i+1]),
			.quo_s1  (d1_quo[i+1]),
			.rem_s1  (d1_rem[i+1]),
			.dv_s1   (d1_dv[i+1]),
			.side_s1 (d1_side[i+1])
		);
		qrs_div_cell #(.NW(NW), .DVW(DVW), .SW(1)) u_second (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (d2_v[i]),
			.num_in  (d2_num[i]),
			.quo_in  (d2_quo[i]),
			.rem_in  (d2_rem[i]),
			.dv_in   (d2_dv[i]),
			.side_in (d2_side[i]),
			.v_s1    (d2_v[i+1]),
			.num_s1  (d2_num[i+1]),
			.quo_s1  (d2_quo[i+1]),
			.rem_s1  (d2_rem[i+1]),
			.dv_s1   (d2_dv[i+1]),
			.side_s1 (d2_side[i+1])
		);
	end

	// ---------------- sign, saturate ----------------
	logic signed [EW-1:0]     q1_w, q2_w;
	logic signed [OUT_W-1:0]  r1_w, r2_w;
	logic                     fin_v;
	logic [1:0]               fin_kind;

	assign fin_v    = d1_v[NW];
	assign fin_kind = d1_side[NW][2:1];
	assign q1_w = d1_side[NW][0] ? -$signed(EW'(d1_quo[NW])) : $signed(EW'(d1_quo[NW]));
	assign q2_w = d2_side[NW][0] ? -$signed(EW'(d2_quo[NW])) : $signed(EW'(d2_quo[NW]));

	always_comb begin
		if (fin_kind == KIND_REJECTED) begin
			r1_w = '0;
			r2_w = '0;
		end else begin
			r1_w = (q1_w > OMAX) ? OMAX[OUT_W-1:0] :
			       (q1_w < OMIN) ? OMIN[OUT_W-1:0] : q1_w[OUT_W-1:0];
			r2_w = (q2_w > OMAX) ? OMAX[OUT_W-1:0] :
			       (q2_w < OMIN) ? OMIN[OUT_W-1:0] : q2_w[OUT_W-1:0];
		end
	end

	// ---------------- output register and skid ----------------
	logic                     out_v_q, skid_v_q;
	logic [1:0]               kind_q, skid_kind_q;
	logic signed [OUT_W-1:0]  first_q, second_q, skid_first_q, skid_second_q;
	logic                     take, load_out, load_skid;

	assign en        = !skid_v_q;
	assign take      = !out_v_q || !out_stall;
	assign load_out  = take && (skid_v_q || fin_v);
	assign load_skid = en && fin_v && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (take) begin
				out_v_q <= skid_v_q || fin_v;
			end
			if (load_skid) begin
				skid_v_q <= 1'b1;
			end else if (take) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q   <= skid_v_q ? skid_kind_q : fin_kind;
			first_q  <= skid_v_q ? skid_first_q : r1_w;
			second_q <= skid_v_q ? skid_second_q : r2_w;
		end
		if (load_skid) begin
			skid_kind_q   <= fin_kind;
			skid_first_q  <= r1_w;
			skid_second_q <= r2_w;
		end
	end

	assign in_stall     = skid_v_q;
	assign out_valid    = out_v_q;
	assign kind         = kind_q;
	assign first_value  = first_q;
	assign second_value = second_q;

	// ---------------- checks ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a request while output is empty");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && kind_q == KIND_REJECTED) |-> (first_q == '0 && second_q == '0))
		else $error("rejected set carries nonzero values");

	a_repeated_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && kind_q == KIND_REPEATED) |-> (first_q == second_q))
		else $error("repeated root differs between fields");

	a_imag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && kind_q == KIND_COMPLEX) |-> !second_q[OUT_W-1])
		else $error("imaginary magnitude is negative");

endmodule
